// ===== src/bfd_pkg.sv =====
// shared types, constants and helpers of the bounded frame deque
package bfd_pkg;

  // ring geometry
  localparam int DEPTH      = 16;
  localparam int FRAME_BITS = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;

  // limit register
  localparam int                LIM_W          = 5;
  localparam logic [LIM_W-1:0]  MAX_FRAMES_RST = 5'd5;

  // configuration port
  localparam int                 PADDR_W         = 3;
  localparam int                 PDATA_W         = 32;
  localparam logic [PADDR_W-1:0] ADDR_MAX_FRAMES = 3'd0;

  // command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  // result queue at the output
  localparam int RQ_DEPTH = 2;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_PLAY    = 2'd1,
    OP_DISCARD = 2'd2,
    OP_DISPLAY = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_EVICTED   = 3'd1,
    ST_PLAYED    = 3'd2,
    ST_DISCARDED = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_LISTED    = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EVICT = 5'b00010,
    S_PUSH  = 5'b00100,
    S_POP   = 5'b01000,
    S_LIST  = 5'b10000
  } state_e;

  typedef struct packed {
    op_e                   op;
    logic [FRAME_BITS-1:0] word;
  } cmd_t;

  typedef struct packed {
    status_e               status;
    logic [FRAME_BITS-1:0] word;
    logic                  last;
  } res_t;

  // ring slot a + b, wrapped once (a below DEPTH, b at most DEPTH)
  function automatic logic [IDX_W-1:0] slot_add(logic [IDX_W-1:0] a, logic [CNT_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== src/bfd_ram.sv =====
// generic single-write, single-read ram with registered read data
module bfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bfd_front.sv =====
// front end: takes requests, decodes the operation, queues commands for the back end
module bfd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [1:0]                     func_i,
  input  logic [bfd_pkg::FRAME_BITS-1:0] frame_word_i,
  output logic                           cmd_valid_o,
  output bfd_pkg::cmd_t                  cmd_o,
  input  logic                           cmd_ready_i
);

  bfd_pkg::cmd_t                 cmd_q [bfd_pkg::CQ_DEPTH];
  logic [bfd_pkg::CQ_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [bfd_pkg::CQ_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [bfd_pkg::CQ_CNT_W-1:0]  cnt_q, cnt_d;
  bfd_pkg::op_e                  op;
  logic                          push_ok;
  logic                          pop_ok;

  // operation decode
  always_comb begin
    case (func_i)
      bfd_pkg::OP_ADD:     op = bfd_pkg::OP_ADD;
      bfd_pkg::OP_PLAY:    op = bfd_pkg::OP_PLAY;
      bfd_pkg::OP_DISCARD: op = bfd_pkg::OP_DISCARD;
      default:             op = bfd_pkg::OP_DISPLAY;
    endcase
  end

  assign full_o      = (cnt_q == bfd_pkg::CQ_CNT_W'(bfd_pkg::CQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cmd_q[rd_ptr_q];
  assign push_ok     = push_i & ~full_o;
  assign pop_ok      = cmd_valid_o & cmd_ready_i;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      if (wr_ptr_q == bfd_pkg::CQ_PTR_W'(bfd_pkg::CQ_DEPTH - 1)) begin
        wr_ptr_d = '0;
      end else begin
        wr_ptr_d = wr_ptr_q + 1'b1;
      end
    end
    if (pop_ok) begin
      if (rd_ptr_q == bfd_pkg::CQ_PTR_W'(bfd_pkg::CQ_DEPTH - 1)) begin
        rd_ptr_d = '0;
      end else begin
        rd_ptr_d = rd_ptr_q + 1'b1;
      end
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // command storage
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      cmd_q[wr_ptr_q] <= '{op: op, word: frame_word_i};
    end
  end

endmodule

// ===== src/bfd_back.sv =====
// back end: ring pointer sequencer, frame store and result queue
module bfd_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  bfd_pkg::cmd_t                  cmd_i,
  output logic                           cmd_ready_o,
  input  logic [bfd_pkg::LIM_W-1:0]      max_frames_i,
  output logic                           empty_o,
  input  logic                           pop_i,
  output bfd_pkg::res_t                  res_o,
  output logic [bfd_pkg::CNT_W-1:0]      fill_o
);

  bfd_pkg::state_e                 state_q, state_d;
  logic [bfd_pkg::IDX_W-1:0]       head_q, head_d;
  logic [bfd_pkg::CNT_W-1:0]       fill_q, fill_d;
  logic [bfd_pkg::IDX_W-1:0]       walk_q, walk_d;
  bfd_pkg::op_e                    op_q, op_d;
  logic [bfd_pkg::FRAME_BITS-1:0]  word_q, word_d;

  logic [bfd_pkg::CNT_W-1:0]       lim;
  logic [bfd_pkg::IDX_W-1:0]       tail_slot;
  logic [bfd_pkg::IDX_W-1:0]       head_next;
  logic [bfd_pkg::CNT_W-1:0]       walk_inc;
  logic                            list_last;

  logic                            ram_we;
  logic [bfd_pkg::IDX_W-1:0]       ram_waddr;
  logic [bfd_pkg::FRAME_BITS-1:0]  ram_wdata;
  logic                            ram_re;
  logic [bfd_pkg::IDX_W-1:0]       ram_raddr;
  logic [bfd_pkg::FRAME_BITS-1:0]  ram_rdata;

  logic                            emit;
  bfd_pkg::res_t                   emit_res;

  bfd_pkg::res_t                   res_q [bfd_pkg::RQ_DEPTH];
  logic [bfd_pkg::RQ_PTR_W-1:0]    rwr_q, rwr_d;
  logic [bfd_pkg::RQ_PTR_W-1:0]    rrd_q, rrd_d;
  logic [bfd_pkg::RQ_CNT_W-1:0]    rcnt_q, rcnt_d;
  logic                            space;
  logic                            res_pop;

  // frame store
  bfd_ram #(
    .WIDTH (bfd_pkg::FRAME_BITS),
    .DEPTH (bfd_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // effective limit, clamped to one..DEPTH
  always_comb begin
    if (max_frames_i == '0) begin
      lim = bfd_pkg::CNT_W'(1);
    end else if (32'(max_frames_i) > 32'(bfd_pkg::DEPTH)) begin
      lim = bfd_pkg::CNT_W'(bfd_pkg::DEPTH);
    end else begin
      lim = bfd_pkg::CNT_W'(max_frames_i);
    end
  end

  assign tail_slot = bfd_pkg::slot_add(head_q, fill_q);
  assign head_next = bfd_pkg::slot_add(head_q, bfd_pkg::CNT_W'(1));
  assign walk_inc  = bfd_pkg::CNT_W'(walk_q) + bfd_pkg::CNT_W'(1);
  assign list_last = (walk_inc == fill_q);
  assign space     = (rcnt_q != bfd_pkg::RQ_CNT_W'(bfd_pkg::RQ_DEPTH));

  // sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    fill_d      = fill_q;
    walk_d      = walk_q;
    op_d        = op_q;
    word_d      = word_q;
    cmd_ready_o = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = tail_slot;
    ram_wdata   = word_q;
    ram_re      = 1'b0;
    ram_raddr   = head_q;
    emit        = 1'b0;
    emit_res    = '{status: bfd_pkg::ST_EMPTY, word: '0, last: 1'b1};
    case (state_q)
      bfd_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == bfd_pkg::OP_ADD) begin
            if (fill_q >= lim) begin
              // full: fetch the oldest frame for eviction
              cmd_ready_o = 1'b1;
              word_d      = cmd_i.word;
              ram_re      = 1'b1;
              state_d     = bfd_pkg::S_EVICT;
            end else if (space) begin
              cmd_ready_o = 1'b1;
              ram_we      = 1'b1;
              ram_wdata   = cmd_i.word;
              fill_d      = fill_q + 1'b1;
              emit        = 1'b1;
              emit_res    = '{status: bfd_pkg::ST_ADDED, word: cmd_i.word, last: 1'b1};
            end
          end else if (fill_q == '0) begin
            if (space) begin
              cmd_ready_o = 1'b1;
              emit        = 1'b1;
            end
          end else begin
            // play, discard or display: start the store read
            cmd_ready_o = 1'b1;
            op_d        = cmd_i.op;
            walk_d      = '0;
            ram_re      = 1'b1;
            if (cmd_i.op == bfd_pkg::OP_DISCARD) begin
              ram_raddr = bfd_pkg::slot_add(head_q, fill_q - 1'b1);
            end
            if (cmd_i.op == bfd_pkg::OP_DISPLAY) begin
              state_d = bfd_pkg::S_LIST;
            end else begin
              state_d = bfd_pkg::S_POP;
            end
          end
        end
      end
      bfd_pkg::S_EVICT: begin
        if (space) begin
          emit     = 1'b1;
          emit_res = '{status: bfd_pkg::ST_EVICTED, word: ram_rdata, last: 1'b0};
          head_d   = head_next;
          fill_d   = fill_q - 1'b1;
          state_d  = bfd_pkg::S_PUSH;
        end
      end
      bfd_pkg::S_PUSH: begin
        if (space) begin
          ram_we   = 1'b1;
          fill_d   = fill_q + 1'b1;
          emit     = 1'b1;
          emit_res = '{status: bfd_pkg::ST_ADDED, word: word_q, last: 1'b1};
          state_d  = bfd_pkg::S_IDLE;
        end
      end
      bfd_pkg::S_POP: begin
        if (space) begin
          emit   = 1'b1;
          fill_d = fill_q - 1'b1;
          if (op_q == bfd_pkg::OP_PLAY) begin
            emit_res = '{status: bfd_pkg::ST_PLAYED, word: ram_rdata, last: 1'b1};
            head_d   = head_next;
          end else begin
            emit_res = '{status: bfd_pkg::ST_DISCARDED, word: ram_rdata, last: 1'b1};
          end
          state_d = bfd_pkg::S_IDLE;
        end
      end
      bfd_pkg::S_LIST: begin
        // one stored frame per cycle while the result queue has space, oldest first
        if (space) begin
          emit     = 1'b1;
          emit_res = '{status: bfd_pkg::ST_LISTED, word: ram_rdata, last: list_last};
          if (list_last) begin
            state_d = bfd_pkg::S_IDLE;
          end else begin
            walk_d    = walk_inc[bfd_pkg::IDX_W-1:0];
            ram_re    = 1'b1;
            ram_raddr = bfd_pkg::slot_add(head_q, walk_inc);
          end
        end
      end
      default: begin
        state_d = bfd_pkg::S_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfd_pkg::S_IDLE;
      head_q  <= '0;
      fill_q  <= '0;
      walk_q  <= '0;
      op_q    <= bfd_pkg::OP_ADD;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      walk_q  <= walk_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  // result queue
  assign empty_o = (rcnt_q == '0);
  assign res_o   = res_q[rrd_q];
  assign res_pop = pop_i & ~empty_o;

  always_comb begin
    rwr_d  = rwr_q;
    rrd_d  = rrd_q;
    rcnt_d = rcnt_q;
    if (emit) begin
      if (rwr_q == bfd_pkg::RQ_PTR_W'(bfd_pkg::RQ_DEPTH - 1)) begin
        rwr_d = '0;
      end else begin
        rwr_d = rwr_q + 1'b1;
      end
    end
    if (res_pop) begin
      if (rrd_q == bfd_pkg::RQ_PTR_W'(bfd_pkg::RQ_DEPTH - 1)) begin
        rrd_d = '0;
      end else begin
        rrd_d = rrd_q + 1'b1;
      end
    end
    if (emit && !res_pop) begin
      rcnt_d = rcnt_q + 1'b1;
    end else if (res_pop && !emit) begin
      rcnt_d = rcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rwr_q  <= '0;
      rrd_q  <= '0;
      rcnt_q <= '0;
    end else begin
      rwr_q  <= rwr_d;
      rrd_q  <= rrd_d;
      rcnt_q <= rcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q[rwr_q] <= emit_res;
    end
  end

  assign fill_o = fill_q;

endmodule

// ===== src/bounded_frame_deque_core.sv =====
// top level of the bounded frame deque: configuration port, front end and back end
//
// Bounded double-ended queue of 32-bit frame handles held in a 16-entry ring.
// Requests enter through a queue-style port (push/full) and results leave through
// another (empty/pop), with a two-entry command queue and a two-entry result queue
// so each side can stall on its own. The fill limit max_frames sits at byte
// address 0 of the APB-style port (reset 5, zero acts as one, values above 16 act
// as 16); the user must write it only while the block is idle, as the block does
// not enforce this. Back-end steps per request: an add without eviction in idle;
// an add with eviction reads the oldest frame, evicts it, then writes the new one;
// play or discard reads its frame, then pops it; any request on an empty queue is
// answered in idle; display lists the stored frames, one listed frame per cycle while
// the result queue has room. No clearing pass after reset; the block accepts at once.
module bounded_frame_deque_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request side
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      func_i,
  input  logic [bfd_pkg::FRAME_BITS-1:0]  frame_word_i,
  // result side
  output logic                            empty,
  input  logic                            pop,
  output logic [2:0]                      status_o,
  output logic [bfd_pkg::FRAME_BITS-1:0]  frame_word_res_o,
  output logic                            last_o,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bfd_pkg::PADDR_W-1:0]     paddr,
  input  logic [bfd_pkg::PDATA_W-1:0]     pwdata,
  output logic [bfd_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);

  logic [bfd_pkg::LIM_W-1:0]  max_frames_q;
  logic                       reg_hit;
  logic                       cfg_wr;
  logic                       cmd_valid;
  bfd_pkg::cmd_t              cmd;
  logic                       cmd_ready;
  bfd_pkg::res_t              res;
  logic [bfd_pkg::CNT_W-1:0]  fill;

  // configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[bfd_pkg::PADDR_W-1:2] == bfd_pkg::ADDR_MAX_FRAMES[bfd_pkg::PADDR_W-1:2]);
  assign cfg_wr  = psel & penable & pwrite & pready & reg_hit;
  assign prdata  = reg_hit ? bfd_pkg::PDATA_W'(max_frames_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frames_q <= bfd_pkg::MAX_FRAMES_RST;
    end else if (cfg_wr) begin
      max_frames_q <= pwdata[bfd_pkg::LIM_W-1:0];
    end
  end

  // front end
  bfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .func_i       (func_i),
    .frame_word_i (frame_word_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_ready_i  (cmd_ready)
  );

  // back end
  bfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_ready_o  (cmd_ready),
    .max_frames_i (max_frames_q),
    .empty_o      (empty),
    .pop_i        (pop),
    .res_o        (res),
    .fill_o       (fill)
  );

  assign status_o         = res.status;
  assign frame_word_res_o = res.word;
  assign last_o           = res.last;

`ifndef SYNTHESIS
  // ring never holds more frames than it has slots
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= bfd_pkg::CNT_W'(bfd_pkg::DEPTH))
    else $error("fill count above ring depth");

  // an eviction is always followed by its add
  a_evict_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == bfd_pkg::ST_EVICTED) |-> !last_o)
    else $error("eviction result marked last");

  // empty status carries no frame and ends the request
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == bfd_pkg::ST_EMPTY) |-> (frame_word_res_o == '0 && last_o))
    else $error("empty status with frame or without last");

  // add, play and discard each end their request
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o == bfd_pkg::ST_ADDED || status_o == bfd_pkg::ST_PLAYED ||
                status_o == bfd_pkg::ST_DISCARDED)) |-> last_o)
    else $error("single-result request not marked last");
`endif

endmodule

// ===== tb/bfd_frame_checker.sv =====
// result checker of the bounded frame deque: predicts every result and compares
`timescale 1ns / 100ps

module bfd_frame_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request side
  input  logic                         push_i,
  input  logic                         full_i,
  input  logic [1:0]                   func_i,
  input  logic [31:0]                  frame_word_i,
  // result side
  input  logic                         empty_i,
  input  logic                         pop_i,
  input  logic [2:0]                   status_i,
  input  logic [31:0]                  frame_word_res_i,
  input  logic                         last_i,
  // configuration port
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic                         pready_i,
  input  logic [bfd_pkg::PADDR_W-1:0]  paddr_i,
  input  logic [bfd_pkg::PDATA_W-1:0]  pwdata_i,
  // towards the testbench top
  output int                           fail_count_o,
  output int                           pending_o
);

  // shadow copy of the deque
  logic [bfd_pkg::FRAME_BITS-1:0] ring_words [bfd_pkg::DEPTH];
  logic [bfd_pkg::IDX_W-1:0]      head_slot;
  logic [bfd_pkg::CNT_W-1:0]      stored_count;
  logic [bfd_pkg::LIM_W-1:0]      fill_limit;

  // results still owed by the block, oldest first
  bfd_pkg::res_t                  owed_results [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // one printed line per mismatch, always counted
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns checker: %s got %h wanted %h", $time, what, got, want);
    fail_count_o++;
  endtask

  // limit as the block applies it: zero acts as one, above the ring acts as full ring
  function automatic int applied_limit();
    if (fill_limit == '0) begin
      return 1;
    end
    if (int'(fill_limit) > bfd_pkg::DEPTH) begin
      return bfd_pkg::DEPTH;
    end
    return int'(fill_limit);
  endfunction

  function automatic logic [bfd_pkg::IDX_W-1:0] ring_slot(input int offset);
    return bfd_pkg::IDX_W'((int'(head_slot) + offset) % bfd_pkg::DEPTH);
  endfunction

  function automatic bfd_pkg::res_t make_result(input bfd_pkg::status_e st,
                                                input logic [31:0] word,
                                                input logic is_last);
    bfd_pkg::res_t r;
    r.status = st;
    r.word   = word;
    r.last   = is_last;
    return r;
  endfunction

  // add one result at the back of the owed list
  task automatic owe_result(input bfd_pkg::res_t r);
    owed_results.insert(owed_results.size(), r);
  endtask

  // work out the results of one accepted request and move the shadow state on
  task automatic predict_request(input bfd_pkg::op_e op, input logic [31:0] word);
    int n;
    case (op)
      bfd_pkg::OP_ADD: begin
        if (int'(stored_count) >= applied_limit()) begin
          owe_result(make_result(bfd_pkg::ST_EVICTED, ring_words[head_slot], 1'b0));
          head_slot    = ring_slot(1);
          stored_count = stored_count - 1'b1;
        end
        ring_words[ring_slot(int'(stored_count))] = word;
        stored_count = stored_count + 1'b1;
        owe_result(make_result(bfd_pkg::ST_ADDED, word, 1'b1));
      end
      bfd_pkg::OP_PLAY: begin
        if (stored_count == '0) begin
          owe_result(make_result(bfd_pkg::ST_EMPTY, '0, 1'b1));
        end else begin
          owe_result(make_result(bfd_pkg::ST_PLAYED, ring_words[head_slot], 1'b1));
          head_slot    = ring_slot(1);
          stored_count = stored_count - 1'b1;
        end
      end
      bfd_pkg::OP_DISCARD: begin
        if (stored_count == '0) begin
          owe_result(make_result(bfd_pkg::ST_EMPTY, '0, 1'b1));
        end else begin
          owe_result(make_result(bfd_pkg::ST_DISCARDED,
              ring_words[ring_slot(int'(stored_count) - 1)], 1'b1));
          stored_count = stored_count - 1'b1;
        end
      end
      default: begin
        if (stored_count == '0) begin
          owe_result(make_result(bfd_pkg::ST_EMPTY, '0, 1'b1));
        end else begin
          for (n = 0; n < int'(stored_count); n++) begin
            owe_result(make_result(bfd_pkg::ST_LISTED, ring_words[ring_slot(n)],
                                   n + 1 == int'(stored_count)));
          end
        end
      end
    endcase
  endtask

  // watch all three ports at every rising edge
  always @(posedge clk_i) begin
    bfd_pkg::res_t want;
    if (!rst_ni) begin
      head_slot    = '0;
      stored_count = '0;
      fill_limit   = bfd_pkg::MAX_FRAMES_RST;
      owed_results.delete();
    end else begin
      // configuration writes
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i == bfd_pkg::ADDR_MAX_FRAMES) begin
        fill_limit = pwdata_i[bfd_pkg::LIM_W-1:0];
      end
      // accepted results against the oldest owed one
      if (pop_i && !empty_i) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result with nothing owed, status/word", 32'(status_i),
                          frame_word_res_i);
        end else begin
          want = owed_results[0];
          owed_results.delete(0);
          if (status_i !== want.status) begin
            report_mismatch("status", 32'(status_i), 32'(want.status));
          end
          if (frame_word_res_i !== want.word) begin
            report_mismatch("frame word", frame_word_res_i, want.word);
          end
          if (last_i !== want.last) begin
            report_mismatch("last flag", 32'(last_i), 32'(want.last));
          end
        end
      end
      // accepted requests
      if (push_i && !full_i) begin
        predict_request(bfd_pkg::op_e'(func_i), frame_word_i);
      end
    end
    pending_o = owed_results.size();
  end

endmodule

// ===== tb/tb_bounded_frame_deque_core.sv =====
// testbench top of the bounded frame deque: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_bounded_frame_deque_core;

  localparam int          CLK_PERIOD  = 4;
  localparam int          RESET_CYCLES = 12;
  localparam int          HOLD_CYCLES = 300;
  localparam int          SETTLE_CYCLES = 40;
  localparam int unsigned TIMEOUT_NS  = 2_000_000;
  localparam int          PAD_W       = bfd_pkg::PDATA_W - bfd_pkg::LIM_W;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          push;
  logic                          full;
  logic [1:0]                    func_sel;
  logic [31:0]                   frame_word;
  logic                          empty;
  logic                          pop;
  logic [2:0]                    status;
  logic [31:0]                   frame_word_res;
  logic                          last_flag;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [bfd_pkg::PADDR_W-1:0]   paddr;
  logic [bfd_pkg::PDATA_W-1:0]   pwdata;
  logic [bfd_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  int                   fail_count;
  int                   pending;
  int                   hold_off_reqs = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  bounded_frame_deque_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .func_i           (func_sel),
    .frame_word_i     (frame_word),
    .empty            (empty),
    .pop              (pop),
    .status_o         (status),
    .frame_word_res_o (frame_word_res),
    .last_o           (last_flag),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  bfd_frame_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_i           (full),
    .func_i           (func_sel),
    .frame_word_i     (frame_word),
    .empty_i          (empty),
    .pop_i            (pop),
    .status_i         (status),
    .frame_word_res_i (frame_word_res),
    .last_i           (last_flag),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // offer one request and hold it until the block takes it
  task automatic offer_request(input bfd_pkg::op_e op, input logic [31:0] word);
    push       <= 1'b1;
    func_sel   <= op;
    frame_word <= word;
    do @(posedge clk_i); while (full);
  endtask

  // stop offering and wait until every owed result has been taken
  task automatic wait_all_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // two-phase write of the fill limit, only while the block is idle
  task automatic write_max_frames(input logic [bfd_pkg::LIM_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bfd_pkg::ADDR_MAX_FRAMES;
    pwdata  <= {PAD_W'($urandom()), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) begin
      return '0;
    end
    if (r == 1) begin
      return '1;
    end
    return $urandom();
  endfunction

  // adds dominate so the ring stays well filled
  function automatic bfd_pkg::op_e pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return bfd_pkg::OP_ADD;
    end
    if (r < 62) begin
      return bfd_pkg::OP_PLAY;
    end
    if (r < 78) begin
      return bfd_pkg::OP_DISCARD;
    end
    return bfd_pkg::OP_DISPLAY;
  endfunction

  // random requests in bursts of random length with random gaps
  task automatic run_random_phase(input int count);
    int burst;
    int gap;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      offer_request(pick_op(), pick_word());
      burst--;
    end
  endtask

  // result side: stall patterns of its own, plus long hold-offs on request
  initial begin : result_drain
    int mode;
    int seg;
    int hold_off_seen;
    hold_off_seen = 0;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(10, 80);
      repeat (seg) begin
        @(posedge clk_i);
        if (hold_off_seen != hold_off_reqs) begin
          hold_off_seen++;
          pop <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          2:       pop <= ($urandom_range(0, 3) == 0);
          default: pop <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // run limit
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb_bounded_frame_deque_core: FAIL");
    $finish;
  end

  // stimulus and verdict
  initial begin : stimulus
    push       = 1'b0;
    func_sel   = bfd_pkg::OP_ADD;
    frame_word = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = bfd_pkg::ADDR_MAX_FRAMES;
    pwdata     = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue answers for play, discard and display
    offer_request(bfd_pkg::OP_PLAY, pick_word());
    offer_request(bfd_pkg::OP_DISCARD, pick_word());
    offer_request(bfd_pkg::OP_DISPLAY, pick_word());
    // fill to the reset limit with extreme words, then evict the oldest
    offer_request(bfd_pkg::OP_ADD, 32'h0000_0000);
    offer_request(bfd_pkg::OP_ADD, 32'hFFFF_FFFF);
    offer_request(bfd_pkg::OP_ADD, $urandom());
    offer_request(bfd_pkg::OP_ADD, $urandom());
    offer_request(bfd_pkg::OP_ADD, $urandom());
    offer_request(bfd_pkg::OP_DISPLAY, '0);
    offer_request(bfd_pkg::OP_ADD, $urandom());
    offer_request(bfd_pkg::OP_DISPLAY, '1);
    wait_all_results();

    // limit lowered below the fill: add evicts one and the fill stays put
    write_max_frames(5'd2);
    offer_request(bfd_pkg::OP_ADD, $urandom());
    offer_request(bfd_pkg::OP_ADD, $urandom());
    offer_request(bfd_pkg::OP_DISPLAY, '0);
    offer_request(bfd_pkg::OP_PLAY, '0);
    offer_request(bfd_pkg::OP_DISCARD, '0);
    offer_request(bfd_pkg::OP_DISPLAY, '0);
    wait_all_results();

    // full ring, with the result side held off so the request side backs up
    write_max_frames(5'd16);
    hold_off_reqs++;
    for (int n = 0; n < 40; n++) begin
      offer_request(pick_op(), pick_word());
    end
    run_random_phase(70);
    wait_all_results();

    write_max_frames(5'd1);
    run_random_phase(50);
    wait_all_results();

    // zero acts as one
    write_max_frames(5'd0);
    run_random_phase(50);
    wait_all_results();

    // above the ring size acts as the ring size
    write_max_frames(5'd31);
    run_random_phase(70);
    wait_all_results();

    write_max_frames(5'd3);
    run_random_phase(70);
    wait_all_results();

    write_max_frames(5'd5);
    run_random_phase(60);
    wait_all_results();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_bounded_frame_deque_core: PASS");
    end else begin
      $display("tb_bounded_frame_deque_core: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/bfd_pkg.sv
src/bfd_ram.sv
src/bfd_front.sv
src/bfd_back.sv
src/bounded_frame_deque_core.sv
tb/bfd_frame_checker.sv
tb/tb_bounded_frame_deque_core.sv
